@@ rtl/sem_pkg.sv @@
// ----------------------------------------------------------------------------
// sem_pkg
// Shared constants, types and the gradient function of the Sobel edge block.
// ----------------------------------------------------------------------------
package sem_pkg;

	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_HEIGHT = 4096;
	localparam int ADDR_W     = $clog2(MAX_WIDTH);
	localparam int CFG_W      = 13;
	localparam int SUM_W      = 18;
	localparam int SQ_W       = 21;

	localparam logic [CFG_W-1:0] WIDTH_MIN  = CFG_W'(2);
	localparam logic [CFG_W-1:0] WIDTH_MAX  = CFG_W'(MAX_WIDTH);
	localparam logic [CFG_W-1:0] HEIGHT_MIN = CFG_W'(1);
	localparam logic [CFG_W-1:0] HEIGHT_MAX = CFG_W'(MAX_HEIGHT);

	localparam logic CFG_IMAGE_WIDTH  = 1'b0;
	localparam logic CFG_IMAGE_HEIGHT = 1'b1;

	localparam logic [SUM_W-1:0] RED_WEIGHT   = SUM_W'(299);
	localparam logic [SUM_W-1:0] GREEN_WEIGHT = SUM_W'(587);
	localparam logic [SUM_W-1:0] BLUE_WEIGHT  = SUM_W'(114);

	// Division by 1000 as a multiplication by the rounded-up reciprocal;
	// exact for every sum the weights can produce.
	localparam int               GRAY_SHIFT = 28;
	localparam logic [18:0]      GRAY_MUL   = 19'd268436;

	typedef struct packed {
		logic accept;
		logic sum;
		logic div;
		logic upd;
		logic grad2;
		logic sq;
		logic root_start;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic has1;
		logic has2;
		logic root_done;
		logic out_free;
	} stat_t;

	typedef struct packed {
		logic signed [10:0] gx;
		logic signed [10:0] gy;
	} grad_t;

	function automatic logic [10:0] weigh(input logic [7:0] a, input logic [7:0] b,
		input logic [7:0] c);
		weigh = {3'b000, a} + {2'b00, b, 1'b0} + {3'b000, c};
	endfunction

	function automatic grad_t sobel_grad(input logic [7:0] l0, input logic [7:0] l1,
		input logic [7:0] l2, input logic [7:0] c0, input logic [7:0] c2,
		input logic [7:0] r0, input logic [7:0] r1, input logic [7:0] r2);
		grad_t g;
		g.gx = $signed(weigh(r0, r1, r2)) - $signed(weigh(l0, l1, l2));
		g.gy = $signed(weigh(l2, c2, r2)) - $signed(weigh(l0, c0, r0));
		sobel_grad = g;
	endfunction

endpackage

@@ rtl/sem_isqrt.sv @@
// ----------------------------------------------------------------------------
// sem_isqrt
// Iterative floor square root, one result bit per cycle, saturated at 255.
// ----------------------------------------------------------------------------
module sem_isqrt (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [sem_pkg::SQ_W-1:0]  value,
	output logic                      done,
	output logic [7:0]                root
);

	logic [15:0] v_q;
	logic [15:0] res_q;
	logic [15:0] bit_q;
	logic [2:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic        sat_q;
	logic [15:0] trial;

	assign trial = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 3'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 3'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd7) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= value[15:0];
			sat_q <= |value[sem_pkg::SQ_W-1:16];
			res_q <= 16'd0;
			bit_q <= 16'h4000;
		end else if (busy_q) begin
			if (v_q >= trial) begin
				v_q   <= v_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = sat_q ? 8'd255 : res_q[7:0];

endmodule

@@ rtl/sem_datapath.sv @@
// ----------------------------------------------------------------------------
// sem_datapath
// Line stores, window, gray conversion, gradient and output register.
// ----------------------------------------------------------------------------
module sem_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  sem_pkg::cmd_t              cmd,
	output sem_pkg::stat_t             stat,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [sem_pkg::CFG_W-1:0]  cfg_wdata,
	input  logic                       mode,
	input  logic [7:0]                 red,
	input  logic [7:0]                 green,
	input  logic [7:0]                 blue,
	input  logic                       out_ready,
	output logic                       out_valid,
	output logic [7:0]                 edge_res,
	output logic                       run_last,
	output logic                       frame_last
);

	localparam int AW = sem_pkg::ADDR_W;
	localparam int CW = sem_pkg::CFG_W;

	logic [7:0] upper_mem [sem_pkg::MAX_WIDTH];
	logic [7:0] middle_mem [sem_pkg::MAX_WIDTH];

	logic [CW-1:0]  width_q, height_q, row_q;
	logic [AW-1:0]  col_q;
	logic           mode_q;
	logic [7:0]     red_q, green_q, blue_q;
	logic [7:0]     up_rd_q, mid_rd_q;
	logic [sem_pkg::SUM_W-1:0] sum_q;
	logic [7:0]     gray_q;
	logic [7:0]     cur_q [3];
	logic [7:0]     win_q [6];
	logic           has1_q, has2_q, drain_q, second_q;
	logic signed [10:0] gx_q, gy_q;
	logic [sem_pkg::SQ_W-1:0] sq_q;
	logic           out_valid_q, run_last_q, frame_last_q;
	logic [7:0]     edge_q;

	logic [CW-1:0]  w_eff, h_eff;
	logic           row_end, drain_row;
	logic [7:0]     bottom;
	logic [36:0]    gray_prod;
	sem_pkg::grad_t g1, g2;
	logic signed [21:0] gx2, gy2;
	logic           root_done;
	logic [7:0]     root;

	always_comb begin
		w_eff = width_q;
		if (width_q < sem_pkg::WIDTH_MIN) w_eff = sem_pkg::WIDTH_MIN;
		if (width_q > sem_pkg::WIDTH_MAX) w_eff = sem_pkg::WIDTH_MAX;
		h_eff = height_q;
		if (height_q < sem_pkg::HEIGHT_MIN) h_eff = sem_pkg::HEIGHT_MIN;
		if (height_q > sem_pkg::HEIGHT_MAX) h_eff = sem_pkg::HEIGHT_MAX;
	end

	assign row_end   = CW'(col_q) >= (w_eff - CW'(1));
	assign drain_row = row_q >= h_eff;
	assign bottom    = mode_q ? mid_rd_q : gray_q;
	assign gray_prod = {19'd0, sum_q} * {18'd0, sem_pkg::GRAY_MUL};

	assign g1 = sem_pkg::sobel_grad(win_q[0], win_q[1], win_q[2], win_q[3], win_q[5],
		up_rd_q, mid_rd_q, bottom);
	assign g2 = sem_pkg::sobel_grad(win_q[0], win_q[1], win_q[2], cur_q[0], cur_q[2],
		cur_q[0], cur_q[1], cur_q[2]);

	assign gx2 = gx_q * gx_q;
	assign gy2 = gy_q * gy_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			up_rd_q  <= upper_mem[col_q];
			mid_rd_q <= middle_mem[col_q];
		end
		if (cmd.upd) begin
			upper_mem[col_q]  <= (row_q == '0) ? bottom : mid_rd_q;
			middle_mem[col_q] <= bottom;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			mode_q  <= mode;
			red_q   <= red;
			green_q <= green;
			blue_q  <= blue;
		end
		if (cmd.sum) begin
			sum_q <= {10'd0, red_q} * sem_pkg::RED_WEIGHT
				+ {10'd0, green_q} * sem_pkg::GREEN_WEIGHT
				+ {10'd0, blue_q} * sem_pkg::BLUE_WEIGHT;
		end
		if (cmd.div) begin
			gray_q <= gray_prod[sem_pkg::GRAY_SHIFT+7:sem_pkg::GRAY_SHIFT];
		end
		if (cmd.upd) begin
			cur_q[0] <= up_rd_q;
			cur_q[1] <= mid_rd_q;
			cur_q[2] <= bottom;
			gx_q     <= g1.gx;
			gy_q     <= g1.gy;
		end
		if (cmd.grad2) begin
			gx_q <= g2.gx;
			gy_q <= g2.gy;
		end
		if (cmd.sq) begin
			sq_q <= gx2[sem_pkg::SQ_W-1:0] + gy2[sem_pkg::SQ_W-1:0];
		end
		if (cmd.load_out) begin
			edge_q       <= root;
			run_last_q   <= second_q | ~has2_q;
			frame_last_q <= second_q & drain_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= sem_pkg::WIDTH_MAX;
			height_q    <= sem_pkg::HEIGHT_MAX;
			col_q       <= '0;
			row_q       <= '0;
			has1_q      <= 1'b0;
			has2_q      <= 1'b0;
			drain_q     <= 1'b0;
			second_q    <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 6; i++) win_q[i] <= 8'd0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == sem_pkg::CFG_IMAGE_WIDTH) width_q <= cfg_wdata;
				else height_q <= cfg_wdata;
			end
			if (cmd.upd) begin
				has1_q   <= (col_q != '0) && (row_q != '0);
				has2_q   <= row_end && (row_q != '0);
				drain_q  <= drain_row;
				second_q <= 1'b0;
				if (col_q == '0) begin
					win_q[0] <= up_rd_q;
					win_q[1] <= mid_rd_q;
					win_q[2] <= bottom;
					win_q[3] <= up_rd_q;
					win_q[4] <= mid_rd_q;
					win_q[5] <= bottom;
				end else begin
					win_q[0] <= win_q[3];
					win_q[1] <= win_q[4];
					win_q[2] <= win_q[5];
					win_q[3] <= up_rd_q;
					win_q[4] <= mid_rd_q;
					win_q[5] <= bottom;
				end
				if (row_end) begin
					col_q <= '0;
					row_q <= drain_row ? '0 : row_q + CW'(1);
				end else begin
					col_q <= col_q + AW'(1);
				end
			end
			if (cmd.grad2) second_q <= 1'b1;
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	sem_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.root_start),
		.value  (sq_q),
		.done   (root_done),
		.root   (root)
	);

	assign stat.has1      = has1_q;
	assign stat.has2      = has2_q;
	assign stat.root_done = root_done;
	assign stat.out_free  = ~out_valid_q | out_ready;

	assign out_valid  = out_valid_q;
	assign edge_res   = edge_q;
	assign run_last   = run_last_q;
	assign frame_last = frame_last_q;

endmodule

@@ rtl/sem_ctrl.sv @@
// ----------------------------------------------------------------------------
// sem_ctrl
// Sequencer that steps one item through the datapath, with zero, one or two results.
// ----------------------------------------------------------------------------
module sem_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  sem_pkg::stat_t stat,
	output sem_pkg::cmd_t  cmd
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_SUM   = 4'd1;
	localparam logic [3:0] S_DIV   = 4'd2;
	localparam logic [3:0] S_UPD   = 4'd3;
	localparam logic [3:0] S_DEC   = 4'd4;
	localparam logic [3:0] S_GRAD2 = 4'd5;
	localparam logic [3:0] S_SQ    = 4'd6;
	localparam logic [3:0] S_ROOT  = 4'd7;
	localparam logic [3:0] S_WAIT  = 4'd8;
	localparam logic [3:0] S_OUT   = 4'd9;

	logic [3:0] state_q, state_d;
	logic       second_q, second_d;

	always_comb begin
		state_d  = state_q;
		second_d = second_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_SUM;
				end
			end
			S_SUM: begin
				cmd.sum = 1'b1;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.div = 1'b1;
				state_d = S_UPD;
			end
			S_UPD: begin
				cmd.upd = 1'b1;
				state_d = S_DEC;
			end
			S_DEC: begin
				second_d = 1'b0;
				if (stat.has1) state_d = S_SQ;
				else if (stat.has2) state_d = S_GRAD2;
				else state_d = S_IDLE;
			end
			S_GRAD2: begin
				cmd.grad2 = 1'b1;
				second_d  = 1'b1;
				state_d   = S_SQ;
			end
			S_SQ: begin
				cmd.sq  = 1'b1;
				state_d = S_ROOT;
			end
			S_ROOT: begin
				cmd.root_start = 1'b1;
				state_d        = S_WAIT;
			end
			S_WAIT: begin
				if (stat.root_done) state_d = S_OUT;
			end
			S_OUT: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					if (!second_q && stat.has2) state_d = S_GRAD2;
					else state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			second_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			second_q <= second_d;
		end
	end

endmodule

@@ rtl/sobel_edge_magnitude.sv @@
// ----------------------------------------------------------------------------
// sobel_edge_magnitude
// Streaming 3x3 Sobel gradient magnitude over RGB pixels with clamped borders.
//
//   channel  signals                              direction
//   in       in_valid in_ready mode red green blue  into block
//   out      out_valid out_ready edge_res run_last   out of block
//            frame_last
//   cfg      cfg_we cfg_index cfg_wdata            into block
//
// An item yields no result, one result or two; with results, most of its time is
// spent in the eight-step square root unit.
// Reset restores both registers to 4096 and clears the counters; line stores
// are not cleared. A stalled output beat holds the sequencer before loading.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       mode,
	input  logic [7:0]                 red,
	input  logic [7:0]                 green,
	input  logic [7:0]                 blue,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [7:0]                 edge_res,
	output logic                       run_last,
	output logic                       frame_last,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [sem_pkg::CFG_W-1:0]  cfg_wdata
);

	sem_pkg::cmd_t  cmd;
	sem_pkg::stat_t stat;

	sem_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	sem_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.mode       (mode),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.edge_res   (edge_res),
		.run_last   (run_last),
		.frame_last (frame_last)
	);

endmodule

@@ dv/sem_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sem_checker
// Watches the pixel, edge and register ports of the Sobel edge block, keeps
// its own model of the line stores, window and raster counters, predicts
// every edge beat and compares each accepted beat with the oldest prediction.
// ----------------------------------------------------------------------------
module sem_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_ready,
	input  logic                      mode,
	input  logic [7:0]                red,
	input  logic [7:0]                green,
	input  logic [7:0]                blue,
	input  logic                      out_valid,
	input  logic                      out_ready,
	input  logic [7:0]                edge_res,
	input  logic                      run_last,
	input  logic                      frame_last,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [sem_pkg::CFG_W-1:0] cfg_wdata,
	output int                        errors,
	output int                        pending
);

	localparam int CW = sem_pkg::CFG_W;

	typedef struct {
		logic [7:0] mag;
		logic       row_done;
		logic       frame_done;
	} edge_beat_t;

	edge_beat_t      edge_queue[$];
	logic [7:0]      top_row[sem_pkg::MAX_WIDTH];
	logic [7:0]      mid_row[sem_pkg::MAX_WIDTH];
	logic [7:0]      win[6];
	int unsigned     col;
	int unsigned     row;
	logic [CW-1:0]   width_reg;
	logic [CW-1:0]   height_reg;

	assign pending = edge_queue.size();

	function automatic logic [7:0] gradient(input int l0, input int l1, input int l2,
		input int c0, input int c2, input int r0, input int r1, input int r2);
		int gx, gy, s, root;
		gx = (r0 + 2 * r1 + r2) - (l0 + 2 * l1 + l2);
		gy = (l2 + 2 * c2 + r2) - (l0 + 2 * c0 + r0);
		s = gx * gx + gy * gy;
		root = 0;
		for (int b = 15; b >= 0; b--)
			if ((root + (1 << b)) * (root + (1 << b)) <= s)
				root += 1 << b;
		return root > 255 ? 8'd255 : 8'(root);
	endfunction

	task automatic predict_pixel(input logic m, input logic [7:0] r, input logic [7:0] g,
		input logic [7:0] b);
		int unsigned w, h, idx;
		logic [7:0] cur[3];
		logic row_end, drain_row;
		edge_beat_t e;
		w = width_reg < 2 ? 2 : (width_reg > sem_pkg::MAX_WIDTH ? sem_pkg::MAX_WIDTH
			: width_reg);
		h = height_reg < 1 ? 1 : (height_reg > sem_pkg::MAX_HEIGHT ? sem_pkg::MAX_HEIGHT
			: height_reg);
		idx = col < sem_pkg::MAX_WIDTH ? col : sem_pkg::MAX_WIDTH - 1;
		row_end = col >= w - 1;
		drain_row = row >= h;
		cur[0] = top_row[idx];
		cur[1] = mid_row[idx];
		cur[2] = m ? mid_row[idx] : 8'((299 * r + 587 * g + 114 * b) / 1000);
		top_row[idx] = row == 0 ? cur[2] : mid_row[idx];
		mid_row[idx] = cur[2];
		if (col == 0) begin
			for (int i = 0; i < 3; i++) begin
				win[i] = cur[i];
				win[i + 3] = cur[i];
			end
		end else begin
			if (row >= 1) begin
				e.mag = gradient(win[0], win[1], win[2], win[3], win[5], cur[0], cur[1], cur[2]);
				e.row_done = row_end ? 1'b0 : 1'b1;
				e.frame_done = 1'b0;
				edge_queue.push_back(e);
			end
			for (int i = 0; i < 3; i++) begin
				win[i] = win[i + 3];
				win[i + 3] = cur[i];
			end
		end
		if (row_end && row >= 1) begin
			e.mag = gradient(win[0], win[1], win[2], cur[0], cur[2], cur[0], cur[1], cur[2]);
			e.row_done = 1'b1;
			e.frame_done = drain_row;
			edge_queue.push_back(e);
		end
		if (row_end) begin
			col = 0;
			row = drain_row ? 0 : row + 1;
		end else begin
			col++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		edge_beat_t e;
		if (!arst_n) begin
			edge_queue.delete();
			foreach (win[i]) win[i] = '0;
			col = 0;
			row = 0;
			width_reg = CW'(sem_pkg::MAX_WIDTH);
			height_reg = CW'(sem_pkg::MAX_HEIGHT);
		end else begin
			if (out_valid && out_ready) begin
				if (edge_queue.size() == 0) begin
					$error("edge beat %0d with no prediction waiting", edge_res);
					errors++;
				end else begin
					e = edge_queue.pop_front();
					if (edge_res !== e.mag) begin
						$error("edge_res expected %0d actual %0d", e.mag, edge_res);
						errors++;
					end
					if (run_last !== e.row_done) begin
						$error("run_last expected %0b actual %0b", e.row_done, run_last);
						errors++;
					end
					if (frame_last !== e.frame_done) begin
						$error("frame_last expected %0b actual %0b", e.frame_done, frame_last);
						errors++;
					end
				end
			end
			if (in_valid && in_ready)
				predict_pixel(mode, red, green, blue);
			if (cfg_we) begin
				if (cfg_index == sem_pkg::CFG_IMAGE_WIDTH)
					width_reg = cfg_wdata;
				else
					height_reg = cfg_wdata;
			end
		end
	end

	initial errors = 0;
endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives raster frames of RGB pixels and drain rows into the Sobel edge
// block under a range of frame sizes, with random gaps on both channels,
// a long output stall and a full drain pause; the checker judges the beats.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int CYCLE_LIMIT = 600000;
	localparam int SETTLE = 80;
	localparam int CW = sem_pkg::CFG_W;
	localparam int MAX_W = sem_pkg::MAX_WIDTH;
	localparam int MAX_H = sem_pkg::MAX_HEIGHT;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	logic             mode;
	logic [7:0]       red;
	logic [7:0]       green;
	logic [7:0]       blue;
	logic             out_valid;
	logic             out_ready;
	logic [7:0]       edge_res;
	logic             run_last;
	logic             frame_last;
	logic             cfg_we;
	logic             cfg_index;
	logic [CW-1:0]    cfg_wdata;
	int               errors;
	int               pending;

	int               sent;
	int unsigned      col;
	int unsigned      row;
	int unsigned      width_used;
	int unsigned      height_used;
	logic             written[MAX_W];
	logic             quiet;
	logic             hold_req;

	sobel_edge_magnitude DUT (.*);
	sem_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		int cycles;
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_req = 1'b0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	task automatic drain_wait();
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_frame(input logic [CW-1:0] w, input logic [CW-1:0] h);
		cfg_we <= 1'b1;
		cfg_index <= sem_pkg::CFG_IMAGE_WIDTH;
		cfg_wdata <= w;
		@(posedge clk);
		cfg_index <= sem_pkg::CFG_IMAGE_HEIGHT;
		cfg_wdata <= h;
		@(posedge clk);
		cfg_we <= 1'b0;
		width_used = w < 2 ? 2 : (w > MAX_W ? MAX_W : w);
		height_used = h < 1 ? 1 : (h > MAX_H ? MAX_H : h);
	endtask

	task automatic send_pixel(input logic m, input logic [7:0] r, input logic [7:0] g,
		input logic [7:0] b);
		if (!quiet && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		red <= r;
		green <= g;
		blue <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent++;
		if (row == 0)
			written[col] = 1'b1;
		if (col >= width_used - 1) begin
			col = 0;
			row = row >= height_used ? 0 : row + 1;
		end else begin
			col++;
		end
	endtask

	function automatic logic [7:0] shade();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic play_pixels(input int count);
		logic m;
		for (int i = 0; i < count; i++) begin
			m = row >= height_used;
			if ($urandom_range(0, 19) == 0)
				m = !m;
			if (m && row == 0 && !written[col])
				m = 1'b0;
			send_pixel(m, shade(), shade(), shade());
		end
	endtask

	task automatic play_frames(input int frames);
		int done;
		done = 0;
		while (done < frames) begin
			if (col >= width_used - 1 && row >= height_used)
				done++;
			play_pixels(1);
		end
		in_valid <= 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = 1'b0;
		red = '0;
		green = '0;
		blue = '0;
		cfg_we = 1'b0;
		cfg_index = sem_pkg::CFG_IMAGE_WIDTH;
		cfg_wdata = '0;
		quiet = 1'b0;
		hold_req = 1'b0;
		sent = 0;
		col = 0;
		row = 0;
		foreach (written[i]) written[i] = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Widest frame, then cut the row short by lowering the width mid-row.
		set_frame(CW'(8191), CW'(8191));
		send_pixel(1'b0, 8'd255, 8'd255, 8'd255);
		send_pixel(1'b0, 8'd0, 8'd0, 8'd0);
		send_pixel(1'b0, 8'd255, 8'd0, 8'd0);
		send_pixel(1'b0, 8'd0, 8'd255, 8'd0);
		send_pixel(1'b0, 8'd0, 8'd0, 8'd255);
		send_pixel(1'b0, 8'd255, 8'd255, 8'd255);
		in_valid <= 1'b0;
		drain_wait();
		set_frame(CW'(3), CW'(5));
		send_pixel(1'b0, 8'd0, 8'd0, 8'd0);
		play_pixels(9);
		in_valid <= 1'b0;
		// Lower the height mid-frame so the current row becomes the drain row.
		drain_wait();
		set_frame(CW'(3), CW'(2));
		play_frames(1);
		drain_wait();

		set_frame(CW'(0), CW'(0));
		send_pixel(1'b0, 8'd255, 8'd255, 8'd255);
		send_pixel(1'b0, 8'd0, 8'd0, 8'd0);
		send_pixel(1'b1, 8'd0, 8'd0, 8'd0);
		send_pixel(1'b1, 8'd255, 8'd255, 8'd255);
		in_valid <= 1'b0;
		drain_wait();

		set_frame(CW'(40), CW'(4));
		hold_req = 1'b1;
		play_frames(1);
		drain_wait();

		while (sent < 700) begin
			if (sent > 600)
				quiet = 1'b1;
			set_frame($urandom_range(0, 9) == 0 ? CW'($urandom_range(0, 1))
				: CW'($urandom_range(2, 12)),
				$urandom_range(0, 9) == 0 ? CW'(0) : CW'($urandom_range(1, 6)));
			play_frames($urandom_range(1, 3));
			drain_wait();
		end

		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
